// ===== rtl/sswf_pkg.sv =====
// Shared types and constants for the stereo sample window front end.
// Holds register indexes, reset values, field widths and the sequencer state type.
// No dependencies.
`default_nettype none

package sswf_pkg;

    // Parameter defaults
    localparam int MAX_BLOCK_DEF      = 8192;
    localparam int MAX_SUM_FRAMES_DEF = 16;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int IDX_W    = 13;
    localparam int OUT_W    = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FPS_W    = 5;
    localparam int BLEN_W   = 14;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT    = 3'd5;

    // Configuration reset values
    localparam logic [FPS_W-1:0]  FPS_RESET  = 5'd1;
    localparam logic [BLEN_W-1:0] BLEN_RESET = 14'd8192;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    // Request codes
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_COEF  = 1'b1;

    // Arithmetic constants
    localparam logic [COEF_W-1:0] UNITY_COEF = 16'd16384;
    localparam int                OUT_SHIFT  = 26;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 26'sh1FFFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -26'sh2000000;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COEF,
        ST_MUL,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/stereo_sample_window_frontend.sv =====
// Stereo sample window front end: byte swap, min/max tracking, frame summing,
// windowing and gain. Uses sswf_pkg for constants, widths and the state type.
// Holds the window coefficient table as a single-port-write, registered-read memory.
//
// Usage:
//   Input channel (i_valid / o_stall) carries either a stereo sample frame
//   (i_req_type = 0) or a window coefficient write (i_req_type = 1). A beat
//   is taken at a rising edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall) carries one result beat per completed
//   output sample: scaled left/right, position in block, last flag and the
//   running block extremes.
//   Sequencing: coefficient writes and frames that do not complete a sample
//   are taken back to back. A frame that completes a sample holds o_stall
//   high while it passes the table read, coefficient times gain, sum times
//   that product, then the shift and saturate into the output register. The
//   two multiplier stages and the one table read port make up this sequence.
//   The output register parts the two sides: while a result waits under
//   i_stall, frames that do not complete a sample are still taken; a frame
//   that completes one waits in the last stage until the register frees.
//   Reset clears the configuration to its defaults, the sums, counts and
//   block position, and starts a new block. The table is not cleared.
//   The user must make configuration writes only while the block is idle;
//   the block itself does not enforce this.
`default_nettype none

module stereo_sample_window_frontend #(
    parameter int MAX_BLOCK      = sswf_pkg::MAX_BLOCK_DEF,
    parameter int MAX_SUM_FRAMES = sswf_pkg::MAX_SUM_FRAMES_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,

    // Configuration write port
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [sswf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [sswf_pkg::CFG_DATA_W-1:0]        i_cfg_data,

    // Input channel
    input  wire logic                                   i_valid,
    output      logic                                   o_stall,
    input  wire logic                                   i_req_type,
    input  wire logic signed [sswf_pkg::SAMPLE_W-1:0]   i_left_raw,
    input  wire logic signed [sswf_pkg::SAMPLE_W-1:0]   i_right_raw,
    input  wire logic [sswf_pkg::IDX_W-1:0]             i_coef_index,
    input  wire logic [sswf_pkg::COEF_W-1:0]            i_coef_value,

    // Output channel
    output      logic                                   o_valid,
    input  wire logic                                   i_stall,
    output      logic signed [sswf_pkg::OUT_W-1:0]      o_left_out,
    output      logic signed [sswf_pkg::OUT_W-1:0]      o_right_out,
    output      logic [sswf_pkg::IDX_W-1:0]             o_sample_position,
    output      logic                                   o_last_of_block,
    output      logic signed [sswf_pkg::SAMPLE_W-1:0]   o_left_min,
    output      logic signed [sswf_pkg::SAMPLE_W-1:0]   o_left_max,
    output      logic signed [sswf_pkg::SAMPLE_W-1:0]   o_right_min,
    output      logic signed [sswf_pkg::SAMPLE_W-1:0]   o_right_max
);

    // Derived widths
    localparam int AW    = $clog2(MAX_BLOCK);
    localparam int LW    = ((AW + 1) > sswf_pkg::BLEN_W) ? (AW + 2) : (sswf_pkg::BLEN_W + 1);
    localparam int IW    = (AW > sswf_pkg::IDX_W) ? (AW + 1) : (sswf_pkg::IDX_W + 1);
    localparam int SUM_W = sswf_pkg::SAMPLE_W + $clog2(MAX_SUM_FRAMES);
    localparam int CNT_W = $clog2(MAX_SUM_FRAMES + 1);
    localparam int FW    = (CNT_W > sswf_pkg::FPS_W) ? (CNT_W + 1) : (sswf_pkg::FPS_W + 1);
    localparam int CG_W  = sswf_pkg::COEF_W + sswf_pkg::GAIN_W;
    localparam int PRW   = SUM_W + CG_W + 1;
    localparam int QW    = PRW - sswf_pkg::OUT_SHIFT;
    localparam int SW    = QW + sswf_pkg::OUT_W;

    // Configuration registers
    logic                            r_swap_bytes;
    logic                            r_window_enable;
    logic [sswf_pkg::FPS_W-1:0]      r_frames_per_sample;
    logic [sswf_pkg::BLEN_W-1:0]     r_block_length;
    logic [sswf_pkg::GAIN_W-1:0]     r_gain_left;
    logic [sswf_pkg::GAIN_W-1:0]     r_gain_right;

    // Control state
    sswf_pkg::t_state                r_state, n_state;
    logic signed [SUM_W-1:0]         r_sum_left, r_sum_right;
    logic [CNT_W-1:0]                r_frame_count;
    logic [AW-1:0]                   r_block_position;
    logic                            r_block_fresh;
    logic                            r_out_valid;

    // Block extremes
    logic signed [sswf_pkg::SAMPLE_W-1:0] r_left_min, r_left_max, r_right_min, r_right_max;

    // Window table and datapath registers
    logic [sswf_pkg::COEF_W-1:0]     r_window_table [MAX_BLOCK];
    logic [sswf_pkg::COEF_W-1:0]     r_rd_data;
    logic [CG_W-1:0]                 r_cg_left, r_cg_right;
    logic signed [PRW-1:0]           r_prod_left, r_prod_right;

    // Output register
    logic signed [sswf_pkg::OUT_W-1:0]    r_out_left, r_out_right;
    logic [sswf_pkg::IDX_W-1:0]           r_out_position;
    logic                                 r_out_last;
    logic signed [sswf_pkg::SAMPLE_W-1:0] r_out_lmin, r_out_lmax, r_out_rmin, r_out_rmax;

    // Combinational signals
    logic                            in_accept;
    logic                            frame_accept;
    logic                            coef_accept;
    logic                            coef_in_range;
    logic                            mem_rd_en;
    logic                            load_out;
    logic                            out_free;
    logic                            sample_done;
    logic                            block_last;
    logic [FW-1:0]                   fps_eff;
    logic [LW-1:0]                   blen_eff;
    logic signed [sswf_pkg::SAMPLE_W-1:0] left_sample, right_sample;
    logic signed [SUM_W-1:0]         n_sum_left, n_sum_right;
    logic [sswf_pkg::COEF_W-1:0]     coef;
    logic signed [sswf_pkg::OUT_W-1:0] sat_left, sat_right;

    // Saturate floor(p / 2^26) to the output range
    function automatic logic signed [sswf_pkg::OUT_W-1:0] scale_sat(
        input logic signed [PRW-1:0] p
    );
        logic signed [QW-1:0] q;
        logic signed [SW-1:0] qx;
        q  = QW'(p >>> sswf_pkg::OUT_SHIFT);
        qx = SW'(q);
        if (qx > SW'(sswf_pkg::OUT_MAX)) begin
            return sswf_pkg::OUT_MAX;
        end else if (qx < SW'(sswf_pkg::OUT_MIN)) begin
            return sswf_pkg::OUT_MIN;
        end
        return sswf_pkg::OUT_W'(qx);
    endfunction

    // Handshake
    assign o_stall      = (r_state != sswf_pkg::ST_IDLE);
    assign in_accept    = i_valid && !o_stall;
    assign frame_accept = in_accept && (i_req_type == sswf_pkg::REQ_FRAME);
    assign coef_accept  = in_accept && (i_req_type == sswf_pkg::REQ_COEF);
    assign out_free     = !r_out_valid || !i_stall;

    // Clamp frames per sample and block length to their working ranges
    always_comb begin
        if (r_frames_per_sample == '0) begin
            fps_eff = FW'(1);
        end else if (FW'(r_frames_per_sample) > FW'(MAX_SUM_FRAMES)) begin
            fps_eff = FW'(MAX_SUM_FRAMES);
        end else begin
            fps_eff = FW'(r_frames_per_sample);
        end
        if (r_block_length == '0) begin
            blen_eff = LW'(1);
        end else if (LW'(r_block_length) > LW'(MAX_BLOCK)) begin
            blen_eff = LW'(MAX_BLOCK);
        end else begin
            blen_eff = LW'(r_block_length);
        end
    end

    // Byte swap and summing
    assign left_sample  = r_swap_bytes ? {i_left_raw[7:0], i_left_raw[15:8]} : i_left_raw;
    assign right_sample = r_swap_bytes ? {i_right_raw[7:0], i_right_raw[15:8]} : i_right_raw;
    assign n_sum_left   = r_sum_left + SUM_W'(left_sample);
    assign n_sum_right  = r_sum_right + SUM_W'(right_sample);
    assign sample_done  = (FW'(r_frame_count) + FW'(1)) >= fps_eff;
    assign block_last   = (LW'(r_block_position) + LW'(1)) >= blen_eff;
    assign coef_in_range = IW'(i_coef_index) < IW'(MAX_BLOCK);
    assign mem_rd_en    = frame_accept && sample_done;

    // Window coefficient or unity
    assign coef = r_window_enable ? r_rd_data : sswf_pkg::UNITY_COEF;

    assign sat_left  = scale_sat(r_prod_left);
    assign sat_right = scale_sat(r_prod_right);

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        case (r_state)
            sswf_pkg::ST_IDLE: begin
                if (mem_rd_en) begin
                    n_state = sswf_pkg::ST_COEF;
                end
            end
            sswf_pkg::ST_COEF: begin
                n_state = sswf_pkg::ST_MUL;
            end
            sswf_pkg::ST_MUL: begin
                n_state = sswf_pkg::ST_EMIT;
            end
            sswf_pkg::ST_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = sswf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sswf_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sswf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap_bytes        <= 1'b0;
            r_window_enable     <= 1'b0;
            r_frames_per_sample <= sswf_pkg::FPS_RESET;
            r_block_length      <= sswf_pkg::BLEN_RESET;
            r_gain_left         <= sswf_pkg::GAIN_RESET;
            r_gain_right        <= sswf_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sswf_pkg::CFG_SWAP_BYTES:    r_swap_bytes        <= i_cfg_data[0];
                sswf_pkg::CFG_WINDOW_ENABLE: r_window_enable     <= i_cfg_data[0];
                sswf_pkg::CFG_FRAMES_PER:    r_frames_per_sample <= i_cfg_data[sswf_pkg::FPS_W-1:0];
                sswf_pkg::CFG_BLOCK_LENGTH:  r_block_length      <= i_cfg_data[sswf_pkg::BLEN_W-1:0];
                sswf_pkg::CFG_GAIN_LEFT:     r_gain_left         <= i_cfg_data;
                sswf_pkg::CFG_GAIN_RIGHT:    r_gain_right        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Window table: write on coefficient beats, read at the block position
    always_ff @(posedge i_clk) begin
        if (coef_accept && coef_in_range) begin
            r_window_table[AW'(i_coef_index)] <= i_coef_value;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_window_table[r_block_position];
        end
    end

    // Accumulate frames, advance sample and block counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_left       <= '0;
            r_sum_right      <= '0;
            r_frame_count    <= '0;
            r_block_position <= '0;
            r_block_fresh    <= 1'b1;
        end else if (load_out) begin
            r_sum_left    <= '0;
            r_sum_right   <= '0;
            r_frame_count <= '0;
            if (block_last) begin
                r_block_position <= '0;
                r_block_fresh    <= 1'b1;
            end else begin
                r_block_position <= r_block_position + AW'(1);
            end
        end else if (frame_accept) begin
            r_sum_left    <= n_sum_left;
            r_sum_right   <= n_sum_right;
            r_frame_count <= r_frame_count + CNT_W'(1);
            r_block_fresh <= 1'b0;
        end
    end

    // Track block extremes; restart on the first frame of a block
    always_ff @(posedge i_clk) begin
        if (frame_accept) begin
            if (r_block_fresh) begin
                r_left_min  <= left_sample;
                r_left_max  <= left_sample;
                r_right_min <= right_sample;
                r_right_max <= right_sample;
            end else begin
                if (left_sample < r_left_min)   r_left_min  <= left_sample;
                if (left_sample > r_left_max)   r_left_max  <= left_sample;
                if (right_sample < r_right_min) r_right_min <= right_sample;
                if (right_sample > r_right_max) r_right_max <= right_sample;
            end
        end
    end

    // Multiply: coefficient times gain, then sum times that product
    always_ff @(posedge i_clk) begin
        if (r_state == sswf_pkg::ST_COEF) begin
            r_cg_left  <= CG_W'(coef) * CG_W'(r_gain_left);
            r_cg_right <= CG_W'(coef) * CG_W'(r_gain_right);
        end
        if (r_state == sswf_pkg::ST_MUL) begin
            r_prod_left  <= PRW'(r_sum_left) * PRW'($signed({1'b0, r_cg_left}));
            r_prod_right <= PRW'(r_sum_right) * PRW'($signed({1'b0, r_cg_right}));
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_left     <= sat_left;
            r_out_right    <= sat_right;
            r_out_position <= sswf_pkg::IDX_W'(r_block_position);
            r_out_last     <= block_last;
            r_out_lmin     <= r_left_min;
            r_out_lmax     <= r_left_max;
            r_out_rmin     <= r_right_min;
            r_out_rmax     <= r_right_max;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_left_out        = r_out_left;
    assign o_right_out       = r_out_right;
    assign o_sample_position = r_out_position;
    assign o_last_of_block   = r_out_last;
    assign o_left_min        = r_out_lmin;
    assign o_left_max        = r_out_lmax;
    assign o_right_min       = r_out_rmin;
    assign o_right_max       = r_out_rmax;

endmodule

`default_nettype wire

// ===== verif/sswf_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the stereo sample window front end: follows register writes and
// input beats, predicts every output beat and compares it field by field.
// Depends on sswf_pkg for widths, register indexes, reset values and request codes.

module sswf_checker
    import sswf_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,

    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_stall,
    input  wire logic                         i_req_type,
    input  wire logic signed [SAMPLE_W-1:0]   i_left_raw,
    input  wire logic signed [SAMPLE_W-1:0]   i_right_raw,
    input  wire logic [IDX_W-1:0]             i_coef_index,
    input  wire logic [COEF_W-1:0]            i_coef_value,

    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_stall,
    input  wire logic signed [OUT_W-1:0]      i_left_out,
    input  wire logic signed [OUT_W-1:0]      i_right_out,
    input  wire logic [IDX_W-1:0]             i_sample_position,
    input  wire logic                         i_last_of_block,
    input  wire logic signed [SAMPLE_W-1:0]   i_left_min,
    input  wire logic signed [SAMPLE_W-1:0]   i_left_max,
    input  wire logic signed [SAMPLE_W-1:0]   i_right_min,
    input  wire logic signed [SAMPLE_W-1:0]   i_right_max,

    output int                                o_failures,
    output int                                o_pending,
    output int                                o_checked
);

    typedef struct {
        logic signed [OUT_W-1:0]    left_out;
        logic signed [OUT_W-1:0]    right_out;
        logic [IDX_W-1:0]           position;
        logic                       last;
        logic signed [SAMPLE_W-1:0] left_min;
        logic signed [SAMPLE_W-1:0] left_max;
        logic signed [SAMPLE_W-1:0] right_min;
        logic signed [SAMPLE_W-1:0] right_max;
    } t_scaled_sample;

    // Shadow copy of the registers
    logic              swap_on;
    logic              window_on;
    logic [FPS_W-1:0]  fps_reg;
    logic [BLEN_W-1:0] blen_reg;
    logic [GAIN_W-1:0] gain_l;
    logic [GAIN_W-1:0] gain_r;

    // Shadow copy of the datapath state
    logic [COEF_W-1:0] coef_tab [MAX_BLOCK_DEF];
    int                sum_l;
    int                sum_r;
    int                frame_cnt;
    int                block_pos;
    logic              block_fresh;
    logic signed [SAMPLE_W-1:0] lo_l, hi_l, lo_r, hi_r;

    t_scaled_sample scaled_sample_q [$];
    int             fail_cnt    = 0;
    int             checked_cnt = 0;

    // Product of sum, coefficient and gain, floored by the arithmetic shift, then clamped
    function automatic logic signed [OUT_W-1:0] scale_sum(int sum, int coef, int gain);
        longint prod;
        prod = longint'(sum) * longint'(coef) * longint'(gain);
        prod = prod >>> OUT_SHIFT;
        if (prod > longint'(OUT_MAX)) prod = longint'(OUT_MAX);
        if (prod < longint'(OUT_MIN)) prod = longint'(OUT_MIN);
        return prod[OUT_W-1:0];
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Swap, track extremes, add into the running sums; queue a beat when a sample completes
    task automatic accumulate_frame(input logic [SAMPLE_W-1:0] l_raw,
                                    input logic [SAMPLE_W-1:0] r_raw);
        int fps_eff;
        int blen_eff;
        int coef;
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        t_scaled_sample s;

        fps_eff = (int'(fps_reg) == 0) ? 1 :
                  (int'(fps_reg) > MAX_SUM_FRAMES_DEF) ? MAX_SUM_FRAMES_DEF : int'(fps_reg);
        blen_eff = (int'(blen_reg) == 0) ? 1 :
                   (int'(blen_reg) > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : int'(blen_reg);

        l = swap_on ? {l_raw[7:0], l_raw[15:8]} : l_raw;
        r = swap_on ? {r_raw[7:0], r_raw[15:8]} : r_raw;

        // First frame of a block restarts the extremes
        if (block_fresh) begin
            lo_l = l;
            hi_l = l;
            lo_r = r;
            hi_r = r;
            block_fresh = 1'b0;
        end else begin
            if (l < lo_l) lo_l = l;
            if (l > hi_l) hi_l = l;
            if (r < lo_r) lo_r = r;
            if (r > hi_r) hi_r = r;
        end

        sum_l = sum_l + int'(l);
        sum_r = sum_r + int'(r);
        frame_cnt++;

        // A count at or past the limit completes the sample, even after a lowered setting
        if (frame_cnt >= fps_eff) begin
            coef        = window_on ? int'(coef_tab[block_pos[IDX_W-1:0]]) : int'(UNITY_COEF);
            s.last      = (block_pos + 1 >= blen_eff);
            s.left_out  = scale_sum(sum_l, coef, int'(gain_l));
            s.right_out = scale_sum(sum_r, coef, int'(gain_r));
            s.position  = block_pos[IDX_W-1:0];
            s.left_min  = lo_l;
            s.left_max  = hi_l;
            s.right_min = lo_r;
            s.right_max = hi_r;
            scaled_sample_q.push_back(s);

            sum_l = 0;
            sum_r = 0;
            frame_cnt = 0;
            if (s.last) begin
                block_pos = 0;
                block_fresh = 1'b1;
            end else begin
                block_pos++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_scaled_sample s;
        if (!i_rst_n) begin
            swap_on     = 1'b0;
            window_on   = 1'b0;
            fps_reg     = FPS_RESET;
            blen_reg    = BLEN_RESET;
            gain_l      = GAIN_RESET;
            gain_r      = GAIN_RESET;
            sum_l       = 0;
            sum_r       = 0;
            frame_cnt   = 0;
            block_pos   = 0;
            block_fresh = 1'b1;
            scaled_sample_q.delete();
        end else begin
            // Follow register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SWAP_BYTES:    swap_on   = i_cfg_data[0];
                    CFG_WINDOW_ENABLE: window_on = i_cfg_data[0];
                    CFG_FRAMES_PER:    fps_reg   = i_cfg_data[FPS_W-1:0];
                    CFG_BLOCK_LENGTH:  blen_reg  = i_cfg_data[BLEN_W-1:0];
                    CFG_GAIN_LEFT:     gain_l    = i_cfg_data;
                    CFG_GAIN_RIGHT:    gain_r    = i_cfg_data;
                    default: ;
                endcase
            end

            // Predict on each accepted input beat
            if (i_in_valid && !i_in_stall) begin
                if (i_req_type == REQ_COEF) begin
                    if (int'(i_coef_index) < MAX_BLOCK_DEF) coef_tab[i_coef_index] = i_coef_value;
                end else begin
                    accumulate_frame(i_left_raw, i_right_raw);
                end
            end

            // Compare each accepted output beat with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (scaled_sample_q.size() == 0) begin
                    $display("%0t unexpected output beat: expected none, got position %0d",
                             $time, i_sample_position);
                    fail_cnt++;
                end else begin
                    s = scaled_sample_q.pop_front();
                    check_field("left_out", longint'(s.left_out), longint'(i_left_out));
                    check_field("right_out", longint'(s.right_out), longint'(i_right_out));
                    check_field("sample_position", longint'(s.position),
                                longint'(i_sample_position));
                    check_field("last_of_block", longint'(s.last), longint'(i_last_of_block));
                    check_field("left_min", longint'(s.left_min), longint'(i_left_min));
                    check_field("left_max", longint'(s.left_max), longint'(i_left_max));
                    check_field("right_min", longint'(s.right_min), longint'(i_right_min));
                    check_field("right_max", longint'(s.right_max), longint'(i_right_max));
                    checked_cnt++;
                end
            end
        end
        o_failures <= fail_cnt;
        o_pending  <= scaled_sample_q.size();
        o_checked  <= checked_cnt;
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Top of the front end testbench: clock, reset, register settings, input stimulus,
// output back-pressure and the verdict. Depends on sswf_pkg, the block and sswf_checker.

module tb;
    import sswf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 16;
    localparam int RAND_PHASES   = 12;
    localparam int TABLE_FILL    = 640;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_req_type;
    logic signed [SAMPLE_W-1:0] i_left_raw;
    logic signed [SAMPLE_W-1:0] i_right_raw;
    logic [IDX_W-1:0]           i_coef_index;
    logic [COEF_W-1:0]          i_coef_value;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [OUT_W-1:0]    o_left_out;
    logic signed [OUT_W-1:0]    o_right_out;
    logic [IDX_W-1:0]           o_sample_position;
    logic                       o_last_of_block;
    logic signed [SAMPLE_W-1:0] o_left_min;
    logic signed [SAMPLE_W-1:0] o_left_max;
    logic signed [SAMPLE_W-1:0] o_right_min;
    logic signed [SAMPLE_W-1:0] o_right_max;

    int fail_count;
    int pending_count;
    int checked_count;

    int   cycle_cnt    = 0;
    int   beats_in     = 0;
    int   cfg_sets     = 0;
    int   tx_gap_pct   = 0;
    int   rx_stall_pct = 0;
    logic rx_quiet     = 1'b1;
    int   rx_burst     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    stereo_sample_window_frontend u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_left_raw        (i_left_raw),
        .i_right_raw       (i_right_raw),
        .i_coef_index      (i_coef_index),
        .i_coef_value      (i_coef_value),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_left_out        (o_left_out),
        .o_right_out       (o_right_out),
        .o_sample_position (o_sample_position),
        .o_last_of_block   (o_last_of_block),
        .o_left_min        (o_left_min),
        .o_left_max        (o_left_max),
        .o_right_min       (o_right_min),
        .o_right_max       (o_right_max)
    );

    sswf_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_req_type        (i_req_type),
        .i_left_raw        (i_left_raw),
        .i_right_raw       (i_right_raw),
        .i_coef_index      (i_coef_index),
        .i_coef_value      (i_coef_value),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_left_out        (o_left_out),
        .i_right_out       (o_right_out),
        .i_sample_position (o_sample_position),
        .i_last_of_block   (o_last_of_block),
        .i_left_min        (o_left_min),
        .i_left_max        (o_left_max),
        .i_right_min       (o_right_min),
        .i_right_max       (o_right_max),
        .o_failures        (fail_count),
        .o_pending         (pending_count),
        .o_checked         (checked_count)
    );

    // Receiver back-pressure: held bursts of stall or free, stall picked at rx_stall_pct percent while rx_quiet is low
    always @(posedge i_clk) begin
        if (rx_burst != 0) begin
            rx_burst <= rx_burst - 1;
        end else if (!rx_quiet && $urandom_range(0, 99) < rx_stall_pct) begin
            i_stall  <= 1'b1;
            rx_burst <= $urandom_range(0, 15);
        end else begin
            i_stall  <= 1'b0;
            rx_burst <= $urandom_range(0, 15);
        end
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, pending_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Mostly random samples, biased toward the sign and byte boundaries
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0080;
            5:       return 16'hFF7F;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return GAIN_RESET;
            default: return GAIN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Drive one beat, optionally after an idle burst, and hold it until taken
    task automatic send_item(logic req, logic [15:0] l_raw, logic [15:0] r_raw,
                             logic [IDX_W-1:0] idx, logic [COEF_W-1:0] value);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_left_raw   <= l_raw;
        i_right_raw  <= r_raw;
        i_coef_index <= idx;
        i_coef_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_in++;
    endtask

    task automatic send_frame(logic [15:0] l_raw, logic [15:0] r_raw);
        send_item(REQ_FRAME, l_raw, r_raw, IDX_W'($urandom_range(0, 8191)),
                  COEF_W'($urandom_range(0, 65535)));
    endtask

    // Hold the sender until every predicted beat is out, then let the pipeline settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [15:0] swap_d, logic [15:0] win_d, logic [15:0] fps_d,
                                  logic [15:0] blen_d, logic [15:0] gl_d, logic [15:0] gr_d);
        wait_drained();
        write_reg(CFG_SWAP_BYTES, swap_d);
        write_reg(CFG_WINDOW_ENABLE, win_d);
        write_reg(CFG_FRAMES_PER, fps_d);
        write_reg(CFG_BLOCK_LENGTH, blen_d);
        write_reg(CFG_GAIN_LEFT, gl_d);
        write_reg(CFG_GAIN_RIGHT, gr_d);
        i_cfg_wr_en <= 1'b0;
        cfg_sets++;
    endtask

    initial begin
        int          phase;
        int          k;
        int          n_items;
        logic [15:0] fps_d;
        logic [15:0] blen_d;
        logic [15:0] value;

        i_rst_n      <= 1'b0;
        i_cfg_wr_en  <= 1'b0;
        i_cfg_index  <= CFG_SWAP_BYTES;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_req_type   <= REQ_FRAME;
        i_left_raw   <= '0;
        i_right_raw  <= '0;
        i_coef_index <= '0;
        i_coef_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the low part of the window table; the run never emits more samples than
        // it holds, so no block position can reach an unwritten entry
        for (k = 0; k < TABLE_FILL; k++) begin
            case (k % 97)
                0:       value = 16'h0000;
                1:       value = 16'hFFFF;
                2:       value = UNITY_COEF;
                default: value = 16'($urandom_range(0, 65535));
            endcase
            send_item(REQ_COEF, rand_sample(), rand_sample(), IDX_W'(k), value);
        end

        // Directed: extreme samples, no window, short block, extreme gains
        apply_settings(16'd0, 16'd0, 16'd1, 16'd4, 16'hFFFF, 16'h0000);
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'h8000, 16'h7FFF);
        send_item(REQ_COEF, 16'h0000, 16'hFFFF, 13'd8191, 16'hFFFF);
        send_frame(16'h0000, 16'hFFFF);
        send_item(REQ_COEF, 16'hFFFF, 16'h0000, 13'd0, 16'h0000);
        send_frame(16'h1234, 16'hFEDC);

        // Directed: byte swap, window on, zero frame count and zero block length act as one
        apply_settings(16'd1, 16'd1, 16'd0, 16'd0, GAIN_RESET, 16'hFFFF);
        send_item(REQ_COEF, 16'h0000, 16'h0000, 13'd0, 16'hFFFF);
        send_frame(16'h0080, 16'hFF7F);
        send_frame(16'h7FFF, 16'h0100);

        // Directed: sixteen frames of full-scale sums, oversized block length clamps
        apply_settings(16'd1, 16'd1, 16'd16, 16'd16383, 16'hFFFF, 16'hFFFF);
        for (k = 0; k < 16; k++) send_frame(16'h0080, 16'hFF7F);

        // Random phases; the last two run without random sender gaps or receiver stalls
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            rx_quiet     <= (phase >= RAND_PHASES - 2);
            rx_stall_pct <= $urandom_range(10, 60);
            tx_gap_pct    = (phase >= RAND_PHASES - 2 || phase % 4 == 3) ? 0
                            : $urandom_range(5, 40);

            case ($urandom_range(0, 9))
                0:       fps_d = 16'd0;
                1:       fps_d = 16'd16;
                2:       fps_d = 16'($urandom_range(17, 31));
                default: fps_d = 16'($urandom_range(1, 4));
            endcase
            if ($urandom_range(0, 3) == 0) fps_d[15:5] = 11'($urandom_range(0, 2047));

            case ($urandom_range(0, 9))
                0:       blen_d = 16'd0;
                1:       blen_d = 16'd1;
                2:       blen_d = 16'd8192;
                3:       blen_d = 16'($urandom_range(8193, 16383));
                default: blen_d = 16'($urandom_range(2, 48));
            endcase
            if ($urandom_range(0, 3) == 0) blen_d[15:14] = 2'($urandom_range(0, 3));

            apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           fps_d, blen_d, pick_gain(), pick_gain());

            n_items = $urandom_range(40, 50);
            for (k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 99) == 0) wait_drained();
                if ($urandom_range(0, 99) < 12) begin
                    send_item(REQ_COEF, rand_sample(), rand_sample(),
                              IDX_W'($urandom_range(0, 8191)),
                              COEF_W'($urandom_range(0, 65535)));
                end else begin
                    send_frame(rand_sample(), rand_sample());
                end
            end
        end

        // Drain and let the pipeline settle before the verdict
        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("summary: %0d input beats, %0d output beats checked, %0d register settings",
                 beats_in, checked_count, cfg_sets);
        $display("summary: window table load, directed extremes, %0d random phases, %0d failures",
                 RAND_PHASES, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sswf_pkg.sv
rtl/stereo_sample_window_frontend.sv
verif/sswf_checker.sv
verif/tb.sv
